/* sv/rc4_pkg.sv */
// RC4 stream cipher package: word types, control word layout and microcode ROM.
// Used by rc4_seq and rc4_stream_cipher; no dependencies.
package rc4_pkg;

    localparam int KEY_STORE_DEPTH = 256;
    localparam int KEY_AW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;
    localparam int PERM_DEPTH = 256;
    localparam int BYTE_W = 8;
    localparam int KEY_LEN_W = 9;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

    typedef enum logic [1:0] {
        MODE_KEY   = 2'd0,
        MODE_SCHED = 2'd1,
        MODE_DATA  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic [BYTE_W-1:0] key_index;
        logic [BYTE_W-1:0] value;
        logic              last_byte;
    } in_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_out;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FILL, ST_FEND,
        ST_K0, ST_K1, ST_K2, ST_K3, ST_KEND,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4
    } step_t;

    typedef enum logic [1:0] {RD_I, RD_INEXT, RD_JNEW, RD_T} rd_sel_t;
    typedef enum logic [1:0] {WR_NONE, WR_FILL, WR_I_RD, WR_J_SI} wr_sel_t;
    typedef enum logic [2:0] {
        C_NEXT, C_ALWAYS, C_I_NOT_LAST, C_NOT_KSA, C_WAIT_OUT, C_DISPATCH
    } cond_t;

    typedef struct packed {
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    add_key;
        logic    si_ld;
        logic    sj_ld;
        logic    j_ld;
        logic    i_inc;
        logic    k_adv;
        logic    ij_clr;
        logic    ksa_clr;
        logic    byp_ld;
        logic    out_ld;
        logic    ready;
        cond_t   cond;
        step_t   target;
    } ctrl_t;

    typedef struct packed {
        logic       accept;
        logic [1:0] mode;
        logic       i_last;
        logic       out_busy;
    } stat_t;

    function automatic ctrl_t ucode(step_t s);
        ctrl_t c;
        c = '0;
        c.rd_sel = RD_I;
        c.wr_sel = WR_NONE;
        c.cond = C_NEXT;
        c.target = ST_IDLE;
        unique case (s)
            ST_IDLE: begin
                c.ready = 1'b1;
                c.cond = C_DISPATCH;
            end
            ST_FILL: begin
                c.wr_sel = WR_FILL;
                c.i_inc = 1'b1;
                c.cond = C_I_NOT_LAST;
                c.target = ST_FILL;
            end
            ST_FEND: begin
                c.ij_clr = 1'b1;
                c.cond = C_NOT_KSA;
                c.target = ST_IDLE;
            end
            ST_K0: begin
                c.rd_sel = RD_I;
            end
            ST_K1: begin
                c.si_ld = 1'b1;
                c.j_ld = 1'b1;
                c.add_key = 1'b1;
                c.rd_sel = RD_JNEW;
            end
            ST_K2: begin
                c.wr_sel = WR_I_RD;
            end
            ST_K3: begin
                c.wr_sel = WR_J_SI;
                c.i_inc = 1'b1;
                c.k_adv = 1'b1;
                c.cond = C_I_NOT_LAST;
                c.target = ST_K0;
            end
            ST_KEND: begin
                c.ij_clr = 1'b1;
                c.ksa_clr = 1'b1;
                c.cond = C_ALWAYS;
                c.target = ST_IDLE;
            end
            ST_P0: begin
                c.i_inc = 1'b1;
                c.rd_sel = RD_INEXT;
            end
            ST_P1: begin
                c.si_ld = 1'b1;
                c.j_ld = 1'b1;
                c.rd_sel = RD_JNEW;
            end
            ST_P2: begin
                c.sj_ld = 1'b1;
                c.wr_sel = WR_I_RD;
            end
            ST_P3: begin
                c.wr_sel = WR_J_SI;
                c.rd_sel = RD_T;
                c.byp_ld = 1'b1;
            end
            ST_P4: begin
                c.rd_sel = RD_T;
                c.out_ld = 1'b1;
                c.cond = C_WAIT_OUT;
                c.target = ST_IDLE;
            end
            default: begin
                c.cond = C_ALWAYS;
                c.target = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

/* sv/rc4_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read returns the old contents on a same-address write. No dependencies.
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                           aclk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/rc4_seq.sv */
// RC4 microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on rc4_pkg.
module rc4_seq (
    input  logic           aclk,
    input  logic           aresetn,
    input  rc4_pkg::stat_t stat,
    output rc4_pkg::ctrl_t cw
);

    rc4_pkg::step_t pc_reg, pc_next;
    logic           ksa_reg, ksa_next;
    rc4_pkg::step_t pc_inc;

    assign cw = rc4_pkg::ucode(pc_reg);
    assign pc_inc = rc4_pkg::step_t'(pc_reg + 4'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= rc4_pkg::ST_FILL;
            ksa_reg <= 1'b0;
        end else begin
            pc_reg <= pc_next;
            ksa_reg <= ksa_next;
        end
    end

    always_comb begin
        pc_next = pc_inc;
        ksa_next = ksa_reg;
        if (cw.ksa_clr) begin
            ksa_next = 1'b0;
        end
        unique case (cw.cond)
            rc4_pkg::C_NEXT:       pc_next = pc_inc;
            rc4_pkg::C_ALWAYS:     pc_next = cw.target;
            rc4_pkg::C_I_NOT_LAST: pc_next = stat.i_last ? pc_inc : cw.target;
            rc4_pkg::C_NOT_KSA:    pc_next = ksa_reg ? pc_inc : cw.target;
            rc4_pkg::C_WAIT_OUT:   pc_next = stat.out_busy ? pc_reg : cw.target;
            rc4_pkg::C_DISPATCH: begin
                pc_next = pc_reg;
                if (stat.accept && stat.mode == rc4_pkg::MODE_SCHED) begin
                    pc_next = rc4_pkg::ST_FILL;
                    ksa_next = 1'b1;
                end else if (stat.accept && stat.mode == rc4_pkg::MODE_DATA) begin
                    pc_next = rc4_pkg::ST_P0;
                end
            end
            default: pc_next = rc4_pkg::ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_data_start: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.accept && stat.mode == rc4_pkg::MODE_DATA |=> pc_reg == rc4_pkg::ST_P0)
        else $error("data word did not start the generator step");
    a_sched_start: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.accept && stat.mode == rc4_pkg::MODE_SCHED
        |=> pc_reg == rc4_pkg::ST_FILL && ksa_reg)
        else $error("schedule word did not start the fill with the schedule flag");
    a_ksa_end: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg == rc4_pkg::ST_K3 && stat.i_last |=> pc_reg == rc4_pkg::ST_KEND)
        else $error("key schedule did not end after the last swap");
`endif

endmodule

/* sv/rc4_stream_cipher.sv */
// RC4 stream cipher top level: APB key length register, key and permutation RAMs,
// datapath driven by the microcode sequencer. Depends on rc4_pkg, rc4_ram, rc4_seq.
//
//   channel | ports                               | moves
//   --------+-------------------------------------+-----------------------------------
//   input   | s_valid, s_ready, s_word            | mode, key_index, value, last_byte
//   result  | m_valid, m_ready, m_word            | out_byte, last_out
//   config  | psel, penable, pwrite, paddr, ...   | key length at address 0
//
// Key byte: written to the key RAM when taken. Data byte: steps P0 to P4, as many as the
// single write port of the permutation RAM demands (two swap writes plus dependent registered reads).
// Key schedule: 256 identity writes (FILL), FEND, 256 swaps (steps K0 to K3), then KEND.
// After reset an identity fill of the permutation runs with s_ready low.
// A waiting result holds in the output register; the next word is still taken,
// and a data word then holds in its last step until the register drains.
module rc4_stream_cipher (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  rc4_pkg::in_word_t              s_word,
    output logic                           m_valid,
    input  logic                           m_ready,
    output rc4_pkg::out_word_t             m_word,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rc4_pkg::APB_AW-1:0]     paddr,
    input  logic [rc4_pkg::APB_DW-1:0]     pwdata,
    output logic [rc4_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    rc4_pkg::ctrl_t cw;
    rc4_pkg::stat_t stat;

    logic accept;
    logic sched_go;
    logic out_busy;
    logic out_fire;

    logic [rc4_pkg::KEY_LEN_W-1:0] key_len_reg, key_len_next;
    logic [rc4_pkg::KEY_LEN_W-1:0] len_eff;
    logic                          cfg_wr;

    logic [rc4_pkg::BYTE_W-1:0] i_reg, i_next;
    logic [rc4_pkg::BYTE_W-1:0] j_reg, j_next;
    logic [rc4_pkg::KEY_AW-1:0] k_reg, k_next;
    logic [rc4_pkg::KEY_LEN_W-1:0] k_inc;
    logic [rc4_pkg::BYTE_W-1:0] si_reg, si_next;
    logic [rc4_pkg::BYTE_W-1:0] sj_reg, sj_next;
    logic                       byp_reg, byp_next;
    logic [rc4_pkg::BYTE_W-1:0] val_reg, val_next;
    logic                       last_reg, last_next;
    logic                       m_valid_reg, m_valid_next;
    rc4_pkg::out_word_t         m_word_reg, m_word_next;

    logic [rc4_pkg::BYTE_W-1:0] perm_rd;
    logic [rc4_pkg::BYTE_W-1:0] key_rd;
    logic [rc4_pkg::BYTE_W-1:0] j_new;
    logic [rc4_pkg::BYTE_W-1:0] t_sum;
    logic [rc4_pkg::BYTE_W-1:0] perm_raddr;
    logic [rc4_pkg::BYTE_W-1:0] perm_waddr;
    logic [rc4_pkg::BYTE_W-1:0] perm_wdata;
    logic                       perm_we;
    logic                       key_we;

    assign s_ready = cw.ready;
    assign accept = s_valid && cw.ready;
    assign sched_go = accept && s_word.mode == rc4_pkg::MODE_SCHED;
    assign out_busy = m_valid_reg && !m_ready;
    assign out_fire = cw.out_ld && !out_busy;
    assign m_valid = m_valid_reg;
    assign m_word = m_word_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[rc4_pkg::APB_AW-1] == 1'b0);
    assign prdata = paddr[rc4_pkg::APB_AW-1] ? '0
                  : rc4_pkg::APB_DW'(key_len_reg);

    always_comb begin
        len_eff = key_len_reg;
        if (key_len_reg == '0) begin
            len_eff = rc4_pkg::KEY_LEN_W'(1);
        end else if (key_len_reg > rc4_pkg::KEY_LEN_W'(rc4_pkg::KEY_STORE_DEPTH)) begin
            len_eff = rc4_pkg::KEY_LEN_W'(rc4_pkg::KEY_STORE_DEPTH);
        end
    end

    assign stat.accept = accept;
    assign stat.mode = s_word.mode;
    assign stat.i_last = (i_reg == '1);
    assign stat.out_busy = out_busy;

    rc4_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cw      (cw)
    );

    assign key_we = accept && s_word.mode == rc4_pkg::MODE_KEY
                 && (rc4_pkg::KEY_LEN_W'(s_word.key_index)
                     < rc4_pkg::KEY_LEN_W'(rc4_pkg::KEY_STORE_DEPTH));

    rc4_ram #(
        .WIDTH (rc4_pkg::BYTE_W),
        .DEPTH (rc4_pkg::KEY_STORE_DEPTH)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (s_word.key_index[rc4_pkg::KEY_AW-1:0]),
        .wdata (s_word.value),
        .raddr (k_reg),
        .rdata (key_rd)
    );

    rc4_ram #(
        .WIDTH (rc4_pkg::BYTE_W),
        .DEPTH (rc4_pkg::PERM_DEPTH)
    ) u_perm_ram (
        .aclk  (aclk),
        .we    (perm_we),
        .waddr (perm_waddr),
        .wdata (perm_wdata),
        .raddr (perm_raddr),
        .rdata (perm_rd)
    );

    assign j_new = j_reg + perm_rd + (cw.add_key ? key_rd : '0);
    assign t_sum = si_reg + sj_reg;
    assign k_inc = rc4_pkg::KEY_LEN_W'(k_reg) + rc4_pkg::KEY_LEN_W'(1);

    always_comb begin
        unique case (cw.rd_sel)
            rc4_pkg::RD_I:     perm_raddr = i_reg;
            rc4_pkg::RD_INEXT: perm_raddr = i_reg + 8'd1;
            rc4_pkg::RD_JNEW:  perm_raddr = j_new;
            rc4_pkg::RD_T:     perm_raddr = t_sum;
            default:           perm_raddr = i_reg;
        endcase
    end

    always_comb begin
        perm_we = 1'b1;
        perm_waddr = i_reg;
        perm_wdata = perm_rd;
        unique case (cw.wr_sel)
            rc4_pkg::WR_NONE: perm_we = 1'b0;
            rc4_pkg::WR_FILL: perm_wdata = i_reg;
            rc4_pkg::WR_I_RD: perm_wdata = perm_rd;
            rc4_pkg::WR_J_SI: begin
                perm_waddr = j_reg;
                perm_wdata = si_reg;
            end
            default: perm_we = 1'b0;
        endcase
    end

    always_comb begin
        key_len_next = cfg_wr ? pwdata[rc4_pkg::KEY_LEN_W-1:0] : key_len_reg;

        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        if (cw.ij_clr || sched_go) begin
            i_next = '0;
            j_next = '0;
            k_next = '0;
        end else begin
            if (cw.i_inc) begin
                i_next = i_reg + 8'd1;
            end
            if (cw.j_ld) begin
                j_next = j_new;
            end
            if (cw.k_adv) begin
                k_next = (k_inc >= len_eff) ? '0 : k_inc[rc4_pkg::KEY_AW-1:0];
            end
        end

        si_next = cw.si_ld ? perm_rd : si_reg;
        sj_next = cw.sj_ld ? perm_rd : sj_reg;
        byp_next = cw.byp_ld ? (t_sum == j_reg) : byp_reg;
        val_next = accept ? s_word.value : val_reg;
        last_next = accept ? s_word.last_byte : last_reg;

        m_valid_next = out_fire || out_busy;
        m_word_next = m_word_reg;
        if (out_fire) begin
            m_word_next.out_byte = val_reg ^ (byp_reg ? si_reg : perm_rd);
            m_word_next.last_out = last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_len_reg <= rc4_pkg::KEY_LEN_RESET;
            i_reg <= '0;
            j_reg <= '0;
            k_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            key_len_reg <= key_len_next;
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        si_reg <= si_next;
        sj_reg <= sj_next;
        byp_reg <= byp_next;
        val_reg <= val_next;
        last_reg <= last_next;
        m_word_reg <= m_word_next;
    end

`ifndef SYNTHESIS
    a_reset_busy: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input taken before the permutation fill");
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !perm_we)
        else $error("permutation written while idle");
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> !$past(s_ready))
        else $error("result appeared without a generator step");
`endif

endmodule
